// ----- hw/rtl/cffa_pkg.sv -----
package cffa_pkg;

    // Widths fixed by the request and result word layouts.
    localparam int CNT_W    = 9;
    localparam int START_W  = 8;
    localparam int STATUS_W = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

    // Request kinds.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Sequencer states of the allocation engine.
    typedef enum logic [2:0] {
        ENG_CLEAR,
        ENG_IDLE,
        ENG_SCAN,
        ENG_MARK,
        ENG_FREE,
        ENG_REPORT
    } eng_state_t;

    // One result word handed from the engine to the output register.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_block;
        logic [CNT_W-1:0]    free_count;
    } res_t;

endpackage

// ----- hw/rtl/cffa_engine.sv -----
module cffa_engine #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: restart the clearing pass with a new free count.
    input  logic                          cfg_we,
    input  logic [cffa_pkg::CNT_W-1:0]    cfg_count,
    // Effective number of usable blocks.
    input  logic [cffa_pkg::CNT_W-1:0]    blk_count,
    // Request side.
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_cmd,
    input  logic [cffa_pkg::CNT_W-1:0]    req_len,
    input  logic [cffa_pkg::START_W-1:0]  req_first,
    // Result side.
    output logic                          res_valid,
    input  logic                          res_ready,
    output cffa_pkg::res_t                res
);
    import cffa_pkg::*;

    localparam int AW       = $clog2(MAX_BLOCKS);
    localparam int CAP_CLIP = (MAX_BLOCKS > 256) ? 256 : MAX_BLOCKS;

    // Block free map: one bit per block, 1 means free.
    logic mem [MAX_BLOCKS];

    eng_state_t           state_reg, state_next;
    logic [AW-1:0]        clr_ptr_reg, clr_ptr_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     eval_reg, eval_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    logic [START_W-1:0]   start_reg, start_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rd_bit_reg;

    logic                 mem_we;
    logic                 mem_wbit;
    logic [AW-1:0]        mem_addr;

    logic                 alloc_reject;
    logic                 free_reject;
    logic                 iss_lt_n;
    logic                 hit;
    logic                 scan_miss;
    logic                 free_end;
    logic                 clr_last;
    logic [CNT_W-1:0]     start_calc;
    logic [CNT_W:0]       free_end_pos;

    // Request checks made on acceptance.
    assign free_end_pos = {2'b00, req_first} + {1'b0, req_len};
    assign alloc_reject = (req_len == '0) || (req_len > free_reg) || (req_len > blk_count);
    assign free_reject  = (req_len == '0) || (free_end_pos > {1'b0, blk_count});

    // Scan conditions: a hit closes a run of free blocks of the asked length.
    assign iss_lt_n   = ptr_reg < blk_count;
    assign hit        = rd_valid_reg && rd_bit_reg && ((run_reg + CNT_W'(1)) == len_reg);
    assign scan_miss  = !rd_valid_reg && !iss_lt_n;
    assign start_calc = eval_reg - len_reg + CNT_W'(1);
    assign free_end   = !rd_valid_reg && (left_reg == '0);
    assign clr_last   = clr_ptr_reg == AW'(MAX_BLOCKS - 1);

    assign mem_addr = (state_reg == ENG_CLEAR) ? clr_ptr_reg : AW'(ptr_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_cmd == CMD_FREE)
                    begin
                        state_next = free_reject ? ENG_REPORT : ENG_FREE;
                    end
                    else
                    begin
                        state_next = alloc_reject ? ENG_REPORT : ENG_SCAN;
                    end
                end
            end
            ENG_SCAN:
            begin
                if (hit)
                begin
                    state_next = ENG_MARK;
                end
                else if (scan_miss)
                begin
                    state_next = ENG_REPORT;
                end
            end
            ENG_MARK:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = ENG_REPORT;
                end
            end
            ENG_FREE:
            begin
                if (free_end)
                begin
                    state_next = ENG_REPORT;
                end
            end
            ENG_REPORT:
            begin
                if (res_ready)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ENG_CLEAR;
        end
    end

    // Datapath and memory controls.
    always_comb
    begin
        clr_ptr_next  = clr_ptr_reg;
        ptr_next      = ptr_reg;
        eval_next     = eval_reg;
        run_next      = run_reg;
        len_next      = len_reg;
        left_next     = left_reg;
        free_next     = free_reg;
        start_next    = start_reg;
        status_next   = status_reg;
        rd_valid_next = 1'b0;
        mem_we        = 1'b0;
        mem_wbit      = 1'b0;
        case (state_reg)
            ENG_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wbit     = 1'b1;
                clr_ptr_next = clr_ptr_reg + AW'(1);
            end
            ENG_IDLE:
            begin
                if (req_valid)
                begin
                    len_next    = req_len;
                    left_next   = req_len;
                    run_next    = '0;
                    start_next  = '0;
                    status_next = ST_DONE;
                    if (req_cmd == CMD_FREE)
                    begin
                        ptr_next = {1'b0, req_first};
                        if (free_reject)
                        begin
                            status_next = ST_BAD;
                        end
                    end
                    else
                    begin
                        ptr_next = '0;
                        if (req_len == '0)
                        begin
                            status_next = ST_BAD;
                        end
                        else if (alloc_reject)
                        begin
                            status_next = ST_NOSPACE;
                        end
                    end
                end
            end
            ENG_SCAN:
            begin
                // Issue the next read while the previous bit is evaluated.
                if (iss_lt_n)
                begin
                    ptr_next      = ptr_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                    eval_next     = ptr_reg;
                end
                if (rd_valid_reg)
                begin
                    run_next = rd_bit_reg ? (run_reg + CNT_W'(1)) : '0;
                end
                if (hit)
                begin
                    ptr_next    = start_calc;
                    left_next   = len_reg;
                    free_next   = free_reg - len_reg;
                    start_next  = start_calc[START_W-1:0];
                    status_next = ST_DONE;
                end
                else if (scan_miss)
                begin
                    status_next = ST_NOSPACE;
                end
            end
            ENG_MARK:
            begin
                mem_we    = 1'b1;
                mem_wbit  = 1'b0;
                ptr_next  = ptr_reg + CNT_W'(1);
                left_next = left_reg - CNT_W'(1);
            end
            ENG_FREE:
            begin
                // Write free and read the old bit at the same address.
                if (left_reg != '0)
                begin
                    mem_we        = 1'b1;
                    mem_wbit      = 1'b1;
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_reg + CNT_W'(1);
                    left_next     = left_reg - CNT_W'(1);
                end
                if (rd_valid_reg && !rd_bit_reg)
                begin
                    free_next = free_reg + CNT_W'(1);
                end
            end
            ENG_REPORT:
            begin
                status_next = status_reg;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
        if (cfg_we)
        begin
            clr_ptr_next = '0;
            free_next    = cfg_count;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ENG_CLEAR;
            clr_ptr_reg  <= '0;
            rd_valid_reg <= 1'b0;
            free_reg     <= CNT_W'(CAP_CLIP);
        end
        else
        begin
            state_reg    <= state_next;
            clr_ptr_reg  <= clr_ptr_next;
            rd_valid_reg <= rd_valid_next;
            free_reg     <= free_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        eval_reg   <= eval_next;
        run_reg    <= run_next;
        len_reg    <= len_next;
        left_reg   <= left_next;
        start_reg  <= start_next;
        status_reg <= status_next;
    end

    // Free map memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wbit;
        end
        rd_bit_reg <= mem[mem_addr];
    end

    assign req_ready       = state_reg == ENG_IDLE;
    assign res_valid       = state_reg == ENG_REPORT;
    assign res.status      = status_reg;
    assign res.start_block = start_reg;
    assign res.free_count  = free_reg;

endmodule

// ----- hw/rtl/contiguous_first_fit_allocator.sv -----
// First-fit contiguous block allocator.
// Requests arrive on the s_axis stream: s_axis_tuser selects allocate (0) or free (1),
// s_axis_tdata carries the run length and, for a free, the first block of the run.
// Each request gives one result word on m_axis: status in m_axis_tuser, start block
// and remaining free count in m_axis_tdata.
// An allocate scans the free map one block per cycle through a single memory port,
// then writes the chosen run one block per cycle. One request is in work at a time,
// and the next one can be taken in the cycle after the result leaves the engine.
// The result sits in an output register, so the next request is taken while a
// finished word waits; a stalled receiver holds that word and, once a second
// result is ready, holds the engine too.
// After reset, and after every write of block_count, a clearing pass marks all
// MAX_BLOCKS blocks free, one per cycle; s_axis_tready stays low meanwhile.
// block_count resets to 256 and is clipped to MAX_BLOCKS, but never above 256.
module contiguous_first_fit_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write of block_count.
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // run_length[8:0], run_start[16:9], zero[23:17]
    input  logic        s_axis_tuser,   // cmd[0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // start_block[7:0], free_count[16:8], zero[23:17]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import cffa_pkg::*;

    localparam int CAP_CLIP = (MAX_BLOCKS > 256) ? 256 : MAX_BLOCKS;

    logic [CNT_W-1:0] block_count_reg;
    logic [CNT_W-1:0] blk_count;
    logic [CNT_W-1:0] cfg_count;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg;
    logic             res_valid;
    logic             res_ready;
    res_t             res;

    // Block count clipped to the built capacity.
    assign blk_count = (block_count_reg > CNT_W'(CAP_CLIP)) ? CNT_W'(CAP_CLIP) : block_count_reg;
    assign cfg_count = (cfg_wdata > CNT_W'(CAP_CLIP)) ? CNT_W'(CAP_CLIP) : cfg_wdata;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= CNT_W'(256);
        end
        else if (cfg_we)
        begin
            block_count_reg <= cfg_wdata;
        end
    end

    cffa_engine #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_count (cfg_count),
        .blk_count (blk_count),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_cmd   (s_axis_tuser),
        .req_len   (s_axis_tdata[8:0]),
        .req_first (s_axis_tdata[16:9]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load when empty or being drained.
    assign res_ready      = !out_valid_reg || m_axis_tready;
    assign out_valid_next = (res_valid && res_ready) || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {7'b0, out_res_reg.free_count, out_res_reg.start_block};

    // A request keeps the engine busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted on back-to-back cycles");

    // A configuration write starts the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("request port open right after configuration write");

    // Only a successful request reports a start block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("start block set on a refused request");

endmodule

// ----- sim/tb_contiguous_first_fit_allocator.sv -----
`timescale 1ns / 100ps

module tb_contiguous_first_fit_allocator;

    import cffa_pkg::*;

    localparam int MAP_SIZE       = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;

    // One request word as the stimulus generator sees it.
    typedef struct {
        logic               cmd;
        logic [CNT_W-1:0]   len;
        logic [START_W-1:0] first;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // run_length[8:0], run_start[16:9], zero[23:17]
    logic        s_axis_tuser = 1'b0;  // cmd[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // start_block[7:0], free_count[16:8], zero[23:17]
    logic [1:0]  m_axis_tuser;         // status[1:0]

    // Allocator mirror: block map, free count and configured size.
    bit               block_free [MAP_SIZE];
    logic [CNT_W-1:0] free_total;
    logic [8:0]       configured_blocks;

    request_t pending_requests [$];
    res_t     expected_results [$];
    int       requests_outstanding = 0;
    bit       req_accepted = 1'b0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       gen_blocks = MAP_SIZE;
    int       mismatches = 0;
    int       quiet_cycles = 0;

    contiguous_first_fit_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Usable blocks: the configured count clipped to the map size.
    function automatic int usable_blocks();
        return (configured_blocks > MAP_SIZE) ? MAP_SIZE : int'(configured_blocks);
    endfunction

    // A size write clears every block to free.
    function automatic void set_block_count(input logic [8:0] value);
        configured_blocks = value;
        foreach (block_free[i])
            block_free[i] = 1'b1;
        free_total = CNT_W'(usable_blocks());
    endfunction

    // Serve one request against the mirror and return the word it should produce.
    function automatic res_t serve_request(input logic cmd, input logic [CNT_W-1:0] len,
                                           input logic [START_W-1:0] first);
        res_t word;
        int   n;
        int   k;
        int   m;
        bit   fits;
        n = usable_blocks();
        word.status = ST_NOSPACE;
        word.start_block = '0;
        if (cmd == CMD_ALLOC)
        begin
            if (len == 0)
                word.status = ST_BAD;
            else if (len <= free_total && int'(len) <= n)
            begin
                // First fit: lowest start whose whole run is free.
                for (k = 0; k + int'(len) <= n && word.status != ST_DONE; k++)
                begin
                    fits = 1'b1;
                    for (m = 0; m < int'(len) && fits; m++)
                        fits = block_free[k + m];
                    if (fits)
                    begin
                        for (m = 0; m < int'(len); m++)
                            block_free[k + m] = 1'b0;
                        free_total = free_total - len;
                        word.start_block = k[START_W-1:0];
                        word.status = ST_DONE;
                    end
                end
            end
        end
        else
        begin
            if (len == 0 || int'(first) + int'(len) > n)
                word.status = ST_BAD;
            else
            begin
                // Only blocks that were in use are counted back.
                for (k = int'(first); k < int'(first) + int'(len); k++)
                begin
                    if (!block_free[k])
                    begin
                        block_free[k] = 1'b1;
                        free_total = free_total + 1'b1;
                    end
                end
                word.status = ST_DONE;
            end
        end
        word.free_count = free_total;
        return word;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Request driver: holds a word until it is taken, idles at random between words.
    always @(negedge clk)
    begin : drive_requests
        request_t next_req;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || req_accepted)
        begin
            req_accepted = 1'b0;
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= next_req.cmd;
                s_axis_tdata <= {7'd0, next_req.first, next_req.len};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: mirrors size writes and accepted requests, checks every result word.
    always @(posedge clk)
    begin : watch_ports
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            set_block_count(9'd256);
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (cfg_we)
            begin
                set_block_count(cfg_wdata);
                quiet_cycles = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(serve_request(s_axis_tuser, s_axis_tdata[8:0],
                                                         s_axis_tdata[16:9]));
                req_accepted = 1'b1;
                requests_outstanding--;
                quiet_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tuser;
                got.start_block = m_axis_tdata[7:0];
                got.free_count = m_axis_tdata[16:8];
                quiet_cycles = 0;
                if (expected_results.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word status=%0d start=%0d free=%0d",
                                            got.status, got.start_block, got.free_count));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.start_block !== want.start_block ||
                        got.free_count !== want.free_count)
                        flag_mismatch($sformatf(
                            "expected status=%0d start=%0d free=%0d, got %0d %0d %0d",
                            want.status, want.start_block, want.free_count,
                            got.status, got.start_block, got.free_count));
                end
            end
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("tb_contiguous_first_fit_allocator NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic cmd, input int len, input int first);
        request_t req;
        req.cmd = cmd;
        req.len = len[CNT_W-1:0];
        req.first = first[START_W-1:0];
        requests_outstanding++;
        pending_requests.push_back(req);
    endtask

    // Mostly small allocations and frees inside the usable range, with some noise.
    task automatic queue_random_request();
        int n;
        int span;
        int pick;
        int len;
        int first;
        n = gen_blocks;
        span = (n >= 8) ? n / 8 : 1;
        pick = $urandom_range(99);
        if (n == 0 || pick < 8)
        begin
            queue_request(1'($urandom_range(1)), $urandom_range(511), $urandom_range(255));
        end
        else if (pick < 52)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(n, 1);
            else
                len = $urandom_range(span, 1);
            queue_request(CMD_ALLOC, len, $urandom_range(255));
        end
        else
        begin
            first = $urandom_range(n - 1);
            len = $urandom_range((n - first < span) ? n - first : span, 1);
            // Now and then a run that ends exactly at, or just past, the last block.
            if ($urandom_range(9) == 0)
                len = n - first + $urandom_range(1);
            queue_request(CMD_FREE, len, first);
        end
    endtask

    // The sender stays quiet until every word has come back.
    task automatic wait_drained();
        while (requests_outstanding != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_block_count(input int value);
        cfg_wdata <= value[8:0];
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        gen_blocks = (value > MAP_SIZE) ? MAP_SIZE : value;
    endtask

    task automatic run_phase(input int cfg_value, input int count,
                             input int sender_pct, input int stall_pct);
        wait_drained();
        if (cfg_value >= 0)
            write_block_count(cfg_value);
        send_idle_pct = sender_pct;
        recv_stall_pct = stall_pct;
        repeat (count) queue_random_request();
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset size of 256 blocks.
        queue_request(CMD_ALLOC, 0, 0);
        queue_request(CMD_ALLOC, 1, 0);
        queue_request(CMD_ALLOC, 256, 0);
        queue_request(CMD_FREE, 0, 5);
        queue_request(CMD_FREE, 1, 255);
        queue_request(CMD_FREE, 1, 0);
        queue_request(CMD_ALLOC, 256, 0);
        queue_request(CMD_ALLOC, 1, 0);
        queue_request(CMD_FREE, 100, 200);
        queue_request(CMD_FREE, 511, 255);
        queue_request(CMD_FREE, 256, 0);
        queue_request(CMD_ALLOC, 511, 0);
        queue_request(CMD_ALLOC, 10, 0);
        queue_request(CMD_ALLOC, 10, 0);
        queue_request(CMD_ALLOC, 10, 0);
        queue_request(CMD_FREE, 10, 10);
        queue_request(CMD_ALLOC, 20, 0);
        queue_request(CMD_ALLOC, 5, 0);
        queue_request(CMD_FREE, 30, 12);
        queue_request(CMD_ALLOC, 255, 0);
        queue_request(CMD_FREE, 256, 0);
        queue_request(CMD_ALLOC, 255, 0);
        queue_request(CMD_ALLOC, 1, 0);
        queue_request(CMD_FREE, 256, 0);

        // Random phases over several sizes, including zero and sizes past the map.
        run_phase(-1, 280, 0, 0);
        run_phase(1, 60, 70, 0);
        run_phase(0, 30, 0, 70);
        run_phase(511, 280, 37, 37);
        run_phase(17, 180, 0, 0);
        run_phase(300, 220, 70, 0);
        run_phase(64, 180, 0, 70);
        run_phase($urandom_range(256, 1), 180, 37, 37);
        run_phase(256, 40, 0, 0);
        wait_drained();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_contiguous_first_fit_allocator OK");
        else
            $display("tb_contiguous_first_fit_allocator NOT OK");
        $finish;
    end

endmodule
